/* rtl/core/mhpq_pkg.sv */
// Shared request/response payload types and operation/status codes for the
// min-heap priority queue. No dependencies.
`default_nettype none

package mhpq_pkg;

	localparam int KEY_W   = 32;
	localparam int TOTAL_W = 11;
	localparam int STAT_W  = 2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] min_value;
		logic                    is_empty;
		logic [TOTAL_W-1:0]      entry_total;
		logic [STAT_W-1:0]       status;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/core/mhpq_store.sv */
// Heap key storage: one write port, two registered read ports.
// Depends on mhpq_pkg for the key width.
`default_nettype none

module mhpq_store #(
	parameter int DEPTH = 1024
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire [$clog2(DEPTH)-1:0]              waddr,
	input  wire signed [mhpq_pkg::KEY_W-1:0]     wdata,
	input  wire [$clog2(DEPTH)-1:0]              ra_addr,
	input  wire [$clog2(DEPTH)-1:0]              rb_addr,
	output logic signed [mhpq_pkg::KEY_W-1:0]    ra_data,
	output logic signed [mhpq_pkg::KEY_W-1:0]    rb_data
);
	import mhpq_pkg::*;

	logic signed [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

`default_nettype wire

/* rtl/core/min_heap_priority_queue.sv */
// Top level of the binary min-heap priority queue: control sequencer,
// count and root registers, response register. Uses mhpq_pkg and mhpq_store.
//
//  channel | dir | payload | handshake
//  --------+-----+---------+-----------------------------------------
//  req     | in  | req_t   | req_valid / req_stall  (push or pop)
//  rsp     | out | rsp_t   | rsp_valid / rsp_stall  (one per request)
//
// One request at a time. Rejected requests, and a pop that empties the heap,
// go straight to the final state. A push steps up through its parents (one
// store read/write per level). A pop walks down from the root (last-entry
// load, then two child reads and a compare-and-write per level) and places
// the moved key when it stops at a leaf or on a compare. Reset clears the
// state, the count and the response valid only; the store is never cleared
// and only entries below the count are used. A stalled response holds; the
// sequencer waits in its final state until the response register is free.
`default_nettype none

module min_heap_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  mhpq_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output mhpq_pkg::rsp_t rsp
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_UP    = 7'b0000010,
		S_POPLD = 7'b0000100,
		S_DNISS = 7'b0001000,
		S_DNCMP = 7'b0010000,
		S_PLACE = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           pos_q;      // current hole
	logic [AW-1:0]           par_q;      // parent of the hole (sift-up)
	logic signed [KEY_W-1:0] key_q;      // key being moved
	logic signed [KEY_W-1:0] root_q;     // mirror of entry 0
	logic [STAT_W-1:0]       status_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	// store ports
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [KEY_W-1:0] wdata;
	logic [AW-1:0]           ra_addr;
	logic [AW-1:0]           rb_addr;
	logic                    rd_en;
	logic signed [KEY_W-1:0] ra_data;
	logic signed [KEY_W-1:0] rb_data;

	mhpq_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.ra_addr(ra_addr),
		.rb_addr(rb_addr),
		.ra_data(ra_data),
		.rb_data(rb_data)
	);

	logic          take;
	logic          out_free;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] par_cnt;
	logic [AW-1:0] par_par;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] c1;
	logic [XW-1:0] c2;
	logic          right_ok;
	logic [XW-1:0] pick_idx;
	logic signed [KEY_W-1:0] pick_val;
	logic [CW+TOTAL_W-1:0]   cnt_ext;

	assign req_stall = (state_q != S_IDLE);
	assign take      = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign cnt_m1  = count_q - CW'(1);
	assign par_cnt = cnt_m1[AW-1:0] >> 1;          // parent of slot count_q
	assign par_par = (par_q - AW'(1)) >> 1;
	assign cnt_x   = XW'(count_q);
	assign c1      = XW'({pos_q, 1'b1});
	assign c2      = c1 + XW'(1);

	// right child only when present and strictly smaller
	assign right_ok = (c2 < cnt_x) && (rb_data < ra_data);
	assign pick_idx = right_ok ? c2 : c1;
	assign pick_val = right_ok ? rb_data : ra_data;

	assign cnt_ext = (CW + TOTAL_W)'(count_q);

	// store access decode
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = key_q;
		ra_addr = par_par;
		rb_addr = c2[AW-1:0];
		rd_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take && req.kind == KIND_PUSH) begin
					ra_addr = par_cnt;
					rd_en   = 1'b1;
				end else if (take) begin
					ra_addr = cnt_m1[AW-1:0];    // last entry
					rd_en   = 1'b1;
				end
			end
			S_UP: begin
				we = 1'b1;
				if (ra_data < key_q) begin
					wdata = key_q;
				end else begin
					wdata = ra_data;               // parent drops into the hole
					rd_en = (par_q != '0);
				end
			end
			S_DNISS: begin
				ra_addr = c1[AW-1:0];
				rb_addr = c2[AW-1:0];
				rd_en   = (c1 < cnt_x);
			end
			S_DNCMP: begin
				if (key_q > pick_val) begin
					we    = 1'b1;
					wdata = pick_val;
				end
			end
			S_PLACE: begin
				we = 1'b1;
			end
			S_POPLD, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new response may replace one being taken in the same cycle
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && req.kind == KIND_PUSH) begin
						if (count_q == CW'(CAPACITY)) begin
							state_q <= S_FIN;
						end else begin
							count_q <= count_q + CW'(1);
							state_q <= (count_q == '0) ? S_PLACE : S_UP;
						end
					end else if (take) begin
						if (count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							count_q <= cnt_m1;
							state_q <= (cnt_m1 == '0) ? S_FIN : S_POPLD;
						end
					end
				end
				S_UP: begin
					if (ra_data < key_q) begin
						state_q <= S_FIN;
					end else if (par_q == '0) begin
						state_q <= S_PLACE;
					end
				end
				S_POPLD: state_q <= S_DNISS;
				S_DNISS: state_q <= (c1 < cnt_x) ? S_DNCMP : S_PLACE;
				S_DNCMP: state_q <= (key_q > pick_val) ? S_DNISS : S_PLACE;
				S_PLACE: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		unique case (state_q)
			S_IDLE: begin
				key_q <= req.key;
				pos_q <= count_q[AW-1:0];
				par_q <= par_cnt;
				if (req.kind == KIND_PUSH) begin
					status_q <= (count_q == CW'(CAPACITY)) ? ST_FULL : ST_DONE;
				end else begin
					status_q <= (count_q == '0) ? ST_EMPTY : ST_DONE;
				end
			end
			S_UP: begin
				if (!(ra_data < key_q)) begin
					pos_q <= par_q;
					par_q <= par_par;
				end
			end
			S_POPLD: begin
				key_q <= ra_data;
				pos_q <= '0;
			end
			S_DNCMP: begin
				if (key_q > pick_val) begin
					pos_q <= pick_idx[AW-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					rsp_q.min_value   <= (count_q != '0) ? root_q : '0;
					rsp_q.is_empty    <= (count_q == '0);
					rsp_q.entry_total <= cnt_ext[TOTAL_W-1:0];
					rsp_q.status      <= status_q;
				end
			end
			S_DNISS, S_PLACE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an enabled read never targets the slot written in the same cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(we && rd_en) |-> (waddr != ra_addr))
		else $error("store read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> req_stall)
		else $error("request accepted while another is in progress");

	a_rsp_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("response raised outside the final state");

endmodule

`default_nettype wire

/* bench/tb_min_heap_priority_queue.sv */
// Self-checking bench for min_heap_priority_queue: directed and random push/pop
// traffic against a behavioral heap predictor, with random stalls on both sides.
// Depends on mhpq_pkg and the RTL of the queue; reads no files.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;

	import mhpq_pkg::*;

	localparam int CAPACITY = 1024;
	localparam int SETTLE_CYCLES = 40;   // a bit past the worst pop walk

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	min_heap_priority_queue #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: our own copy of the heap, updated when a request is
	// accepted. Ties on sift-up still swap; sift-down prefers the left
	// child unless the right one is strictly smaller.
	// ------------------------------------------------------------------
	logic signed [KEY_W-1:0] heap_keys [CAPACITY];
	int unsigned heap_count = 0;

	rsp_t expected_outcomes [$];
	int fail_count = 0;

	// shared idling controls
	bit smooth = 1'b0;            // when set, neither side idles
	int pressure_hold = 0;        // receiver holds off this many cycles

	function automatic rsp_t apply_heap_op(req_t r);
		rsp_t res;
		int unsigned pos;
		int unsigned up;
		int unsigned pick;
		int unsigned other;
		logic signed [KEY_W-1:0] t;
		res.status = ST_DONE;
		if (r.kind == KIND_PUSH) begin
			if (heap_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				heap_keys[heap_count] = r.key;
				pos = heap_count;
				heap_count++;
				while (pos != 0) begin
					up = (pos - 1) / 2;
					if (heap_keys[up] < heap_keys[pos])
						break;
					t = heap_keys[up];
					heap_keys[up] = heap_keys[pos];
					heap_keys[pos] = t;
					pos = up;
				end
			end
		end else begin
			if (heap_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				heap_count--;
				heap_keys[0] = heap_keys[heap_count];
				pos = 0;
				forever begin
					pick = 2 * pos + 1;
					other = 2 * pos + 2;
					if (pick >= heap_count)
						break;
					if (other < heap_count && heap_keys[other] < heap_keys[pick])
						pick = other;
					if (!(heap_keys[pos] > heap_keys[pick]))
						break;
					t = heap_keys[pos];
					heap_keys[pos] = heap_keys[pick];
					heap_keys[pick] = t;
					pos = pick;
				end
			end
		end
		res.min_value = (heap_count != 0) ? heap_keys[0] : '0;
		res.is_empty = (heap_count == 0);
		res.entry_total = TOTAL_W'(heap_count);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (smooth)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Key mix: extremes, a narrow band that forces ties, full-range values.
	function automatic logic signed [KEY_W-1:0] random_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		if (r < 40)
			return $signed(KEY_W'($urandom_range(0, 32))) - 16;
		return $urandom;
	endfunction

	// ------------------------------------------------------------------
	// Sender. Entered and left at a falling edge. Valid stays high
	// across back-to-back requests; only the payload changes.
	// ------------------------------------------------------------------
	task automatic send_request(input logic kind, input logic signed [KEY_W-1:0] key);
		int gap;
		req_t item;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.kind = kind;
		item.key = key;
		req = item;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		expected_outcomes.push_back(apply_heap_op(item));
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver: drives rsp_stall at the falling edge. A pressure request
	// from a test takes priority over the random stall pattern.
	// ------------------------------------------------------------------
	int stall_left = 0;
	int run_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall = 1'b0;
		end else if (pressure_hold > 0) begin
			rsp_stall = 1'b1;
			pressure_hold--;
		end else if (stall_left > 0) begin
			rsp_stall = 1'b1;
			stall_left--;
		end else if (run_left > 0) begin
			rsp_stall = 1'b0;
			run_left--;
		end else begin
			rsp_stall = 1'b0;
			stall_left = pick_gap();
			run_left = $urandom_range(0, 8);
		end
	end

	// ------------------------------------------------------------------
	// Checker: every accepted response against the oldest expectation.
	// ------------------------------------------------------------------
	task automatic report_field(input string name, input longint want, input longint got);
		$display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t ns: unexpected response, expected none, actual min %0d total %0d",
					$time, rsp.min_value, rsp.entry_total);
				fail_count++;
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp.min_value !== want.min_value)
					report_field("min_value", want.min_value, rsp.min_value);
				if (rsp.is_empty !== want.is_empty)
					report_field("is_empty", want.is_empty, rsp.is_empty);
				if (rsp.entry_total !== want.entry_total)
					report_field("entry_total", want.entry_total, rsp.entry_total);
				if (rsp.status !== want.status)
					report_field("status", want.status, rsp.status);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Pops on an empty heap are rejected; key is don't-care on a pop.
	task automatic test_pop_when_empty();
		send_request(KIND_POP, KEY_MAX);
		send_request(KIND_POP, KEY_MIN);
	endtask

	// Both key extremes, zero, -1 and 1, then drain down through the last entry and pop once more on the empty heap.
	task automatic test_key_extremes();
		send_request(KIND_PUSH, '0);
		send_request(KIND_PUSH, KEY_MAX);
		send_request(KIND_PUSH, KEY_MIN);
		send_request(KIND_PUSH, -1);
		send_request(KIND_PUSH, 1);
		repeat (5)
			send_request(KIND_POP, '0);
		send_request(KIND_POP, -1);
	endtask

	// Ties: equal keys still swap going up and must not swap coming down.
	task automatic test_equal_keys();
		send_request(KIND_PUSH, 5);
		send_request(KIND_PUSH, 5);
		send_request(KIND_PUSH, 5);
		send_request(KIND_PUSH, -3);
		send_request(KIND_PUSH, -3);
		send_request(KIND_PUSH, 5);
		repeat (6)
			send_request(KIND_POP, '0);
	endtask

	// Receiver holds off for a long stretch while the sender keeps
	// offering back to back; the queue must stall its request side.
	task automatic test_backpressure();
		@(posedge clk);
		pressure_hold = 200;
		smooth = 1'b1;
		@(negedge clk);
		repeat (6)
			send_request(KIND_PUSH, random_key());
		send_request(KIND_POP, '0);
		send_request(KIND_POP, '0);
		smooth = 1'b0;
	endtask

	// Mixed push/pop; the push share leans away from the empty and full ends
	// so that the heap wanders but rejections still happen now and then.
	task automatic test_random_mix(input int n_items, input int push_pct);
		int pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0)
				smooth = ($urandom_range(0, 3) == 0);
			if (heap_count == 0)
				pct = 70;
			else if (heap_count >= CAPACITY)
				pct = 30;
			else
				pct = push_pct;
			if ($urandom_range(0, 99) < pct)
				send_request(KIND_PUSH, random_key());
			else
				send_request(KIND_POP, random_key());
		end
		smooth = 1'b0;
	endtask

	// Fill to capacity for full-depth sifts, knock on the full heap,
	// then work near the top for a while.
	task automatic test_fill_and_overflow();
		int n;
		n = 0;
		while (heap_count < CAPACITY) begin
			if (n % 128 == 0)
				smooth = ($urandom_range(0, 2) == 0);
			send_request(KIND_PUSH, random_key());
			n++;
		end
		smooth = 1'b0;
		send_request(KIND_PUSH, KEY_MIN);
		send_request(KIND_PUSH, KEY_MAX);
		send_request(KIND_PUSH, random_key());
		repeat (40)
			send_request(KIND_POP, random_key());
		test_random_mix(120, 60);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_pop_when_empty();
		test_key_extremes();
		test_equal_keys();
		test_backpressure();
		test_random_mix(100, 55);
		test_fill_and_overflow();

		req_valid = 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
